### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the console engine top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Console engine package
// Grid geometry, character codes, item types and state encodings.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int LIN_W  = 12;
    localparam int CELL_W = 16;

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_SETPOS = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    localparam logic [COL_W:0] TAB_STEP = 8'd8;
    localparam logic [COL_W:0] TAB_MASK = ~8'd7;

    localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_BLANK};

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  new_column;
        logic [ROW_W-1:0]  new_row;
        logic [IDX_W-1:0]  cell_index;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [LIN_W-1:0]  cursor_linear;
        logic [CELL_W-1:0] read_data;
        logic              scrolled;
    } t_out_item;

    typedef enum logic [3:0] {
        KIND_NOP,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_TAB,
        KIND_BACKSPACE,
        KIND_PRINT,
        KIND_CLEAR,
        KIND_SETPOS,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_BLANK,
        S_REPORT
    } t_state;

endpackage

### src/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/tcce_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module tcce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_data,
    input  logic           i_pop,
    output tcce_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);

    tcce_pkg::t_cmd                   r_mem [tcce_pkg::QUEUE_DEPTH];
    logic [tcce_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [tcce_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [tcce_pkg::QCNT_W-1:0]      r_count, n_count;

    localparam logic [tcce_pkg::QPTR_W-1:0] PTR_LAST =
        tcce_pkg::QPTR_W'(tcce_pkg::QUEUE_DEPTH - 1);
    localparam logic [tcce_pkg::QCNT_W-1:0] CNT_FULL =
        tcce_pkg::QCNT_W'(tcce_pkg::QUEUE_DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);

endmodule

### src/tcce_front.sv
// ----------------------------------------------------------------------------
// Console front end
// Accepts items, decodes control bytes and range checks, and queues commands.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic               start,
    input  tcce_pkg::t_in_item i_item,
    input  logic               i_full,
    input  logic               i_init,
    output logic               busy,
    output logic               o_push,
    output tcce_pkg::t_cmd     o_cmd
);

    always_comb begin
        o_cmd.kind = tcce_pkg::KIND_NOP;
        o_cmd.ch   = i_item.char_code;
        o_cmd.col  = i_item.new_column;
        o_cmd.row  = i_item.new_row;
        o_cmd.addr = tcce_pkg::ADDR_W'(i_item.cell_index);
        case (i_item.operation)
            tcce_pkg::OP_PUT: begin
                case (i_item.char_code)
                    tcce_pkg::CH_NEWLINE:   o_cmd.kind = tcce_pkg::KIND_NEWLINE;
                    tcce_pkg::CH_RETURN:    o_cmd.kind = tcce_pkg::KIND_RETURN;
                    tcce_pkg::CH_TAB:       o_cmd.kind = tcce_pkg::KIND_TAB;
                    tcce_pkg::CH_BACKSPACE: o_cmd.kind = tcce_pkg::KIND_BACKSPACE;
                    default: begin
                        if (i_item.char_code >= tcce_pkg::CH_PRINT_LO &&
                            i_item.char_code <= tcce_pkg::CH_PRINT_HI) begin
                            o_cmd.kind = tcce_pkg::KIND_PRINT;
                        end
                    end
                endcase
            end
            tcce_pkg::OP_CLEAR: begin
                o_cmd.kind = tcce_pkg::KIND_CLEAR;
            end
            tcce_pkg::OP_SETPOS: begin
                if (32'(i_item.new_column) < tcce_pkg::COLUMNS &&
                    32'(i_item.new_row) < tcce_pkg::ROWS) begin
                    o_cmd.kind = tcce_pkg::KIND_SETPOS;
                end
            end
            tcce_pkg::OP_READ: begin
                if (32'(i_item.cell_index) < tcce_pkg::CELLS) begin
                    o_cmd.kind = tcce_pkg::KIND_READ;
                end
            end
            default: o_cmd.kind = tcce_pkg::KIND_NOP;
        endcase
    end

    assign busy   = i_full || i_init;
    assign o_push = start && !busy;

endmodule

### src/tcce_back.sv
// ----------------------------------------------------------------------------
// Console back end
// Executes queued commands on the cell memory and cursor, and issues results.
// ----------------------------------------------------------------------------
module tcce_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_attr,
    input  tcce_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_pop,
    output logic                          o_init,
    output logic                          o_strobe,
    output tcce_pkg::t_out_item           o_result
);

    tcce_pkg::t_state                 r_state, n_state;
    logic [tcce_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [tcce_pkg::ADDR_W-1:0]      r_cp_addr, n_cp_addr;
    logic                             r_cp_valid, n_cp_valid;
    logic [tcce_pkg::COL_W-1:0]       r_col, n_col;
    logic [tcce_pkg::ROW_W-1:0]       r_row, n_row;
    logic                             r_scrolled, n_scrolled;
    logic                             r_is_read, n_is_read;
    logic                             r_strobe, n_strobe;
    tcce_pkg::t_out_item              r_result, n_result;

    logic                             ram_we;
    logic [tcce_pkg::ADDR_W-1:0]      ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]      ram_wdata;
    logic [tcce_pkg::ADDR_W-1:0]      ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]      ram_rdata;

    logic [tcce_pkg::ADDR_W-1:0]      w_lin;
    logic [tcce_pkg::COL_W:0]         col_x;
    logic [tcce_pkg::ROW_W:0]         row_x;
    logic                             put_we;
    logic [tcce_pkg::ADDR_W-1:0]      put_addr;
    logic [tcce_pkg::CHAR_W-1:0]      put_char;
    logic                             put_scroll;
    logic                             is_put;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_lin = tcce_pkg::ADDR_W'(32'(r_row) * tcce_pkg::COLUMNS + 32'(r_col));

    assign is_put = (i_cmd.kind == tcce_pkg::KIND_NEWLINE) ||
                    (i_cmd.kind == tcce_pkg::KIND_RETURN) ||
                    (i_cmd.kind == tcce_pkg::KIND_TAB) ||
                    (i_cmd.kind == tcce_pkg::KIND_BACKSPACE) ||
                    (i_cmd.kind == tcce_pkg::KIND_PRINT);

    // Cursor movement and cell write for a put, including wrap and scroll.
    always_comb begin
        col_x      = {1'b0, r_col};
        row_x      = {1'b0, r_row};
        put_we     = 1'b0;
        put_addr   = w_lin;
        put_char   = i_cmd.ch;
        put_scroll = 1'b0;
        case (i_cmd.kind)
            tcce_pkg::KIND_NEWLINE: begin
                col_x = '0;
                row_x = row_x + 1'b1;
            end
            tcce_pkg::KIND_RETURN: begin
                col_x = '0;
            end
            tcce_pkg::KIND_TAB: begin
                col_x = (col_x + tcce_pkg::TAB_STEP) & tcce_pkg::TAB_MASK;
            end
            tcce_pkg::KIND_BACKSPACE: begin
                if (r_col != '0) begin
                    col_x    = col_x - 1'b1;
                    put_we   = 1'b1;
                    put_addr = w_lin - 1'b1;
                    put_char = tcce_pkg::CH_BLANK;
                end
            end
            tcce_pkg::KIND_PRINT: begin
                put_we = 1'b1;
                col_x  = col_x + 1'b1;
            end
            default: begin
            end
        endcase
        if (32'(col_x) >= tcce_pkg::COLUMNS) begin
            col_x = '0;
            row_x = row_x + 1'b1;
        end
        if (32'(row_x) >= tcce_pkg::ROWS) begin
            put_scroll = 1'b1;
            row_x      = (tcce_pkg::ROW_W + 1)'(tcce_pkg::ROWS - 1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcce_pkg::S_INIT: begin
                if (r_addr == tcce_pkg::LAST_CELL) begin
                    n_state = tcce_pkg::S_IDLE;
                end
            end
            tcce_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == tcce_pkg::KIND_CLEAR) begin
                        n_state = tcce_pkg::S_BLANK;
                    end else if (is_put && put_scroll) begin
                        n_state = (tcce_pkg::ROWS > 1) ? tcce_pkg::S_SCROLL
                                                        : tcce_pkg::S_BLANK;
                    end else begin
                        n_state = tcce_pkg::S_REPORT;
                    end
                end
            end
            tcce_pkg::S_SCROLL: begin
                if (r_addr == tcce_pkg::SCROLL_LAST) begin
                    n_state = tcce_pkg::S_BLANK;
                end
            end
            tcce_pkg::S_BLANK: begin
                if (!r_cp_valid && r_addr == tcce_pkg::LAST_CELL) begin
                    n_state = tcce_pkg::S_REPORT;
                end
            end
            tcce_pkg::S_REPORT: n_state = tcce_pkg::S_IDLE;
            default:            n_state = tcce_pkg::S_INIT;
        endcase
    end

    always_comb begin
        n_addr     = r_addr;
        n_cp_addr  = r_addr;
        n_cp_valid = 1'b0;
        n_col      = r_col;
        n_row      = r_row;
        n_scrolled = r_scrolled;
        n_is_read  = r_is_read;
        n_strobe   = 1'b0;
        n_result   = r_result;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = {i_attr, tcce_pkg::CH_BLANK};
        ram_raddr  = r_addr;
        // A copied cell is written in the cycle after its read.
        if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end
        case (r_state)
            tcce_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = tcce_pkg::RESET_CELL;
                n_addr    = r_addr + 1'b1;
            end
            tcce_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop      = 1'b1;
                    n_scrolled = 1'b0;
                    n_is_read  = 1'b0;
                    n_addr     = '0;
                    if (is_put) begin
                        n_col      = col_x[tcce_pkg::COL_W-1:0];
                        n_row      = row_x[tcce_pkg::ROW_W-1:0];
                        n_scrolled = put_scroll;
                        ram_we     = put_we;
                        ram_waddr  = put_addr;
                        ram_wdata  = {i_attr, put_char};
                    end else if (i_cmd.kind == tcce_pkg::KIND_CLEAR) begin
                        n_col = '0;
                        n_row = '0;
                    end else if (i_cmd.kind == tcce_pkg::KIND_SETPOS) begin
                        n_col = i_cmd.col;
                        n_row = i_cmd.row;
                    end else if (i_cmd.kind == tcce_pkg::KIND_READ) begin
                        ram_raddr = i_cmd.addr;
                        n_is_read = 1'b1;
                    end
                end
            end
            tcce_pkg::S_SCROLL: begin
                ram_raddr  = r_addr + tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS);
                n_cp_valid = 1'b1;
                n_cp_addr  = r_addr;
                n_addr     = r_addr + 1'b1;
            end
            tcce_pkg::S_BLANK: begin
                if (!r_cp_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = {i_attr, tcce_pkg::CH_BLANK};
                    n_addr    = r_addr + 1'b1;
                end
            end
            tcce_pkg::S_REPORT: begin
                n_strobe               = 1'b1;
                n_result.cursor_column = r_col;
                n_result.cursor_row    = r_row;
                n_result.cursor_linear = tcce_pkg::LIN_W'(
                    32'(r_row) * tcce_pkg::COLUMNS + 32'(r_col));
                n_result.read_data     = r_is_read ? ram_rdata : '0;
                n_result.scrolled      = r_scrolled;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcce_pkg::S_INIT;
            r_addr     <= '0;
            r_cp_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_cp_valid <= n_cp_valid;
            r_col      <= n_col;
            r_row      <= n_row;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr  <= n_cp_addr;
        r_scrolled <= n_scrolled;
        r_is_read  <= n_is_read;
        r_result   <= n_result;
    end

    assign o_init   = (r_state == tcce_pkg::S_INIT);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### src/text_console_char_engine_core.sv
// A taken item passes through the command queue, the back end's issue and report states and
// the result register before its result appears; a scroll or a clear adds memory sweeps.
// The back end takes a new command only after it has reported the last one; the single write
// port of the cell memory sets the length of the scroll and clear sweeps.
// Reset: busy stays high during a clearing pass that writes the reset cell to every cell.
// Results are issued for one cycle each on o_strobe; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Text console character engine
// Top level: configuration register, front end, command queue and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tcce_pkg::t_in_item          i_item,
    output logic                        o_strobe,
    output tcce_pkg::t_out_item         o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcce_pkg::CHAR_W-1:0] i_cfg_data
);

    logic [tcce_pkg::CHAR_W-1:0] r_color_attr, n_color_attr;
    logic                        push;
    logic                        pop;
    logic                        full;
    logic                        empty;
    logic                        init;
    tcce_pkg::t_cmd              front_cmd;
    tcce_pkg::t_cmd              queue_cmd;
    logic                        cursor_in_grid;
    logic                        cursor_on_last_row;

    assign o_cfg_ready  = 1'b1;
    assign n_color_attr = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_color_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_attr <= tcce_pkg::RESET_ATTR;
        end else begin
            r_color_attr <= n_color_attr;
        end
    end

    tcce_front u_front (
        .start  (start),
        .i_item (i_item),
        .i_full (full),
        .i_init (init),
        .busy   (busy),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_color_attr),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (!empty),
        .o_pop       (pop),
        .o_init      (init),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    assign cursor_in_grid     = (32'(o_result.cursor_column) < tcce_pkg::COLUMNS) &&
                                (32'(o_result.cursor_row) < tcce_pkg::ROWS);
    assign cursor_on_last_row = (32'(o_result.cursor_row) == tcce_pkg::ROWS - 1);

    `ASSERT_NEXT(a_strobe_spacing, o_strobe, !o_strobe, "results issued on adjacent cycles")
    `ASSERT_SAME(a_cursor_range, o_strobe, cursor_in_grid, "cursor outside the grid")
    `ASSERT_SAME(a_scroll_row, o_strobe && o_result.scrolled, cursor_on_last_row, "scroll missed")
    `ASSERT_ALWAYS(a_no_accept_in_init, !(init && push), "item taken during clearing pass")

endmodule

### tb/sv/tcce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console engine checker
// Watches the item, result and attribute channels of the console engine and
// keeps its own copy of the character grid, cursor and attribute. Each item
// taken by the engine is applied to that copy, and the report it should give
// is queued; each strobed result is compared field by field with the oldest
// queued report.
// ----------------------------------------------------------------------------
module tcce_checker
    import tcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in_item    i_item,
    input  logic        i_strobe,
    input  t_out_item   i_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_scrolls
);

    logic [CELL_W-1:0] grid [0:CELLS-1];
    int                cur_col;
    int                cur_row;
    logic [7:0]        attr;
    t_out_item         expected_reports [$];
    t_out_item         want;
    int                shown;

    function automatic t_out_item apply_console_op(t_in_item it);
        t_out_item rep;
        int        i;
        rep = '0;
        case (it.operation)
            OP_PUT: begin
                if (it.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (it.char_code == CH_RETURN) begin
                    cur_col = 0;
                end else if (it.char_code == CH_TAB) begin
                    cur_col = (cur_col / 8 + 1) * 8;
                end else if (it.char_code == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        grid[cur_row * COLUMNS + cur_col] = {attr, CH_BLANK};
                    end
                end else if (it.char_code >= CH_PRINT_LO && it.char_code <= CH_PRINT_HI) begin
                    grid[cur_row * COLUMNS + cur_col] = {attr, it.char_code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        grid[i] = grid[i + COLUMNS];
                    for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        grid[i] = {attr, CH_BLANK};
                    cur_row = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    grid[i] = {attr, CH_BLANK};
                cur_col = 0;
                cur_row = 0;
            end
            OP_SETPOS: begin
                if (it.new_column < COLUMNS && it.new_row < ROWS) begin
                    cur_col = it.new_column;
                    cur_row = it.new_row;
                end
            end
            default: begin
                if (it.cell_index < CELLS)
                    rep.read_data = grid[it.cell_index];
            end
        endcase
        rep.cursor_column = COL_W'(cur_col);
        rep.cursor_row    = ROW_W'(cur_row);
        rep.cursor_linear = LIN_W'(cur_row * COLUMNS + cur_col);
        return rep;
    endfunction

    function automatic void field_check(string field, int unsigned exp_v,
                                        logic [CELL_W-1:0] got_v, logic ok);
        if (!ok) begin
            o_fail_count++;
            if (shown < 40) begin
                shown++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v,
                         got_v);
            end
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_scrolls    = 0;
        shown        = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                grid[i] = RESET_CELL;
            cur_col = 0;
            cur_row = 0;
            attr    = RESET_ATTR;
            expected_reports.delete();
        end else begin
            if (i_strobe) begin
                if (expected_reports.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, i_result);
                end else begin
                    want = expected_reports.pop_front();
                    o_checked++;
                    if (want.scrolled)
                        o_scrolls++;
                    field_check("cursor_column", want.cursor_column, i_result.cursor_column,
                                i_result.cursor_column === want.cursor_column);
                    field_check("cursor_row", want.cursor_row, i_result.cursor_row,
                                i_result.cursor_row === want.cursor_row);
                    field_check("cursor_linear", want.cursor_linear, i_result.cursor_linear,
                                i_result.cursor_linear === want.cursor_linear);
                    field_check("read_data", want.read_data, i_result.read_data,
                                i_result.read_data === want.read_data);
                    field_check("scrolled", want.scrolled, i_result.scrolled,
                                i_result.scrolled === want.scrolled);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                attr = i_cfg_data;
            if (i_start && !i_busy)
                expected_reports.push_back(apply_console_op(i_item));
        end
        o_pending <= expected_reports.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console engine testbench
// Drives the text console engine with a short directed run over the control
// bytes, wrapping, scrolling, clearing and out-of-range requests, then with
// random streams of text, cursor moves and cell reads under several attribute
// settings. Results are checked by the checker module beside the engine.
// ----------------------------------------------------------------------------
module testbench;
    import tcce_pkg::*;

    localparam int PAUSE_CYCLES = 2 * CELLS + 32;
    localparam int PHASE_ITEMS  = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   console_item;
    logic       strobe;
    t_out_item  console_result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         checked;
    int         scrolls;
    int         items_sent;
    int         burst_left;

    text_console_char_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (console_item),
        .o_strobe    (strobe),
        .o_result    (console_result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    tcce_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (console_item),
        .i_strobe     (strobe),
        .i_result     (console_result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #(100_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_in_item make_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                           int col, int row, int idx);
        t_in_item it;
        it.operation  = op;
        it.char_code  = ch;
        it.new_column = COL_W'(col);
        it.new_row    = ROW_W'(row);
        it.cell_index = IDX_W'(idx);
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       sel;
        it = make_item(OP_PUT, CHAR_W'($urandom), $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                it.char_code = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            else if (sel < 80)
                it.char_code = CH_NEWLINE;
            else if (sel < 85)
                it.char_code = CH_TAB;
            else if (sel < 90)
                it.char_code = CH_BACKSPACE;
            else if (sel < 93)
                it.char_code = CH_RETURN;
        end else if (pick < 72) begin
            it.operation  = OP_SETPOS;
            it.new_column = COL_W'($urandom_range(0, COLUMNS - 1));
            if ($urandom_range(0, 1))
                it.new_row = ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
            else
                it.new_row = ROW_W'($urandom_range(0, ROWS - 1));
        end else if (pick < 74) begin
            it.operation = OP_SETPOS;
        end else if (pick < 94) begin
            it.operation = OP_READ;
            if ($urandom_range(0, 99) < 85)
                it.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
        end else if (pick < 95) begin
            it.operation = OP_CLEAR;
        end else begin
            it.operation = OP_W'($urandom);
        end
        return it;
    endfunction

    task automatic send(input t_in_item it);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 15);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        console_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy)
            @(negedge i_clk);
        repeat (PAUSE_CYCLES) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] attrs [4];
        i_rst_n      = 1'b0;
        start        = 1'b0;
        console_item = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        burst_left   = 0;
        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = 8'($urandom);
        attrs[3] = 8'($urandom);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(make_item(OP_READ, 0, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, CELLS - 1));
        send(make_item(OP_READ, 0, 0, 0, CELLS));
        send(make_item(OP_READ, 0, 0, 0, 2047));
        send(make_item(OP_PUT, 8'h41, 0, 0, 0));
        send(make_item(OP_PUT, CH_PRINT_HI, 0, 0, 0));
        send(make_item(OP_PUT, CH_BLANK, 0, 0, 0));
        send(make_item(OP_PUT, 8'h00, 0, 0, 0));
        send(make_item(OP_PUT, 8'hFF, 0, 0, 0));
        send(make_item(OP_PUT, 8'h80, 0, 0, 0));
        send(make_item(OP_PUT, CH_TAB, 0, 0, 0));
        send(make_item(OP_PUT, CH_BACKSPACE, 0, 0, 0));
        send(make_item(OP_PUT, CH_RETURN, 0, 0, 0));
        send(make_item(OP_PUT, CH_BACKSPACE, 0, 0, 0));
        send(make_item(OP_SETPOS, 0, 127, 31, 2047));
        send(make_item(OP_SETPOS, 0, COLUMNS - 1, 0, 0));
        send(make_item(OP_PUT, 8'h7E, 0, 0, 0));
        send(make_item(OP_SETPOS, 0, COLUMNS - 1, ROWS - 1, 0));
        send(make_item(OP_PUT, CH_TAB, 0, 0, 0));
        send(make_item(OP_PUT, CH_NEWLINE, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, (ROWS - 1) * COLUMNS));
        send(make_item(OP_SETPOS, 0, COLUMNS, 0, 0));
        send(make_item(OP_CLEAR, 0, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, CELLS - 1));
        send(make_item(OP_SETPOS, 0, 0, ROWS, 0));

        foreach (attrs[p]) begin
            write_attr(attrs[p]);
            repeat (PHASE_ITEMS)
                send(random_item());
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (64) @(negedge i_clk);

        $display("Sent %0d items under five attribute settings; %0d results checked.",
                 items_sent, checked);
        $display("The grid scrolled %0d times; %0d mismatches were found.", scrolls,
                 fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### text_console_char_engine_core.f
+incdir+src
src/tcce_pkg.sv
src/tcce_ram.sv
src/tcce_queue.sv
src/tcce_front.sv
src/tcce_back.sv
src/text_console_char_engine_core.sv
tb/sv/tcce_checker.sv
tb/sv/testbench.sv
